/* rtl/assert_macros.svh */
// Assertion macros used by the top level of the combination table.
// No dependencies; include inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_RST(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Checked on every clock edge, reset included.
`define ASSERT_ALW(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

/* rtl/sdct_pkg.sv */
// Types, constants and compare functions of the sorted combination table.
// No dependencies.
`default_nettype none

package sdct_pkg;

    localparam int CAPACITY = 1024;
    localparam int NUMS     = 6;
    localparam int NUM_W    = 7;
    localparam int ADDR_W   = 10;
    localparam int CNT_W    = 11;
    localparam int ENTRY_W  = NUMS * NUM_W;
    localparam int STAT_W   = 3;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // index 0 holds the first number
    typedef logic [NUMS-1:0][NUM_W-1:0] entry_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_INSERTED  = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_READ_OK   = 3'd3,
        STAT_OUT_RANGE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_READ,
        ST_FIN
    } state_t;

    // every number of e is found somewhere in n
    function automatic logic covers(entry_t e, entry_t n);
        logic all_hit;
        logic hit;
        all_hit = 1'b1;
        for (int j = 0; j < NUMS; j++) begin
            hit = 1'b0;
            for (int k = 0; k < NUMS; k++) begin
                hit = hit | (e[j] == n[k]);
            end
            all_hit = all_hit & hit;
        end
        return all_hit;
    endfunction

    // lexicographic a < b, first number most significant
    function automatic logic less_than(entry_t a, entry_t b);
        logic lt;
        logic decided;
        lt      = 1'b0;
        decided = 1'b0;
        for (int j = 0; j < NUMS; j++) begin
            if (!decided && (a[j] != b[j])) begin
                lt      = a[j] < b[j];
                decided = 1'b1;
            end
        end
        return lt;
    endfunction

endpackage

`default_nettype wire

/* rtl/sdct_ram.sv */
// Simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module sdct_ram #(
    parameter int DATA_W = 42,
    parameter int ADDR_W = 10
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/sorted_dedup_combination_table_top.sv */
// Top level of the sorted combination table with duplicate rejection.
// Depends on sdct_pkg, sdct_ram and assert_macros.svh.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------
//  s_      | in  | s_valid / s_ready  | req_type, num_a..num_f, read_index
//  m_      | out | m_valid / m_ready  | status, entry_count, position,
//          |     |                    | out_a..out_f
//
// One item at a time. An insert first scans the N stored entries for a
// duplicate (one RAM read a cycle), then moves the N - P entries from
// its sorted place P up one place toward the tail (one read and one
// write a cycle). The single RAM read port sets this pace.
// Reset (aresetn low, synchronous) empties the table; entry contents are
// left as they are and are never read before written.
// A result waiting on m_ready holds the block in its final state; the
// output register is freed the cycle the item is taken.
`default_nettype none

module sorted_dedup_combination_table_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_req_type,
    input  wire logic [sdct_pkg::NUM_W-1:0]    s_num_a,
    input  wire logic [sdct_pkg::NUM_W-1:0]    s_num_b,
    input  wire logic [sdct_pkg::NUM_W-1:0]    s_num_c,
    input  wire logic [sdct_pkg::NUM_W-1:0]    s_num_d,
    input  wire logic [sdct_pkg::NUM_W-1:0]    s_num_e,
    input  wire logic [sdct_pkg::NUM_W-1:0]    s_num_f,
    input  wire logic [sdct_pkg::ADDR_W-1:0]   s_read_index,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [sdct_pkg::STAT_W-1:0]   m_status,
    output logic      [sdct_pkg::CNT_W-1:0]    m_entry_count,
    output logic      [sdct_pkg::ADDR_W-1:0]   m_position,
    output logic      [sdct_pkg::NUM_W-1:0]    m_out_a,
    output logic      [sdct_pkg::NUM_W-1:0]    m_out_b,
    output logic      [sdct_pkg::NUM_W-1:0]    m_out_c,
    output logic      [sdct_pkg::NUM_W-1:0]    m_out_d,
    output logic      [sdct_pkg::NUM_W-1:0]    m_out_e,
    output logic      [sdct_pkg::NUM_W-1:0]    m_out_f
);

    import sdct_pkg::*;
    `include "assert_macros.svh"

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;     // entries stored
    entry_t              nw_reg, nw_next;           // item being inserted
    status_t             status_reg, status_next;   // result being built
    logic [ADDR_W-1:0]   pos_reg, pos_next;         // read index / position
    // iss_reg: scan = next address to read; shift = entries still below
    logic [CNT_W-1:0]    iss_reg, iss_next;
    logic                pend_reg, pend_next;       // RAM read in flight
    logic [ADDR_W-1:0]   pend_idx_reg, pend_idx_next;

    logic                m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]   m_status_reg, m_status_next;
    logic [CNT_W-1:0]    m_count_reg, m_count_next;
    logic [ADDR_W-1:0]   m_pos_reg, m_pos_next;
    entry_t              m_vals_reg, m_vals_next;

    // RAM port
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    entry_t              wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    entry_t              rd_data;

    sdct_ram #(
        .DATA_W (ENTRY_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ---------------------------------------------------------------
    // Shared conditions
    // ---------------------------------------------------------------
    logic              in_fire;
    logic              out_free;
    logic              scan_hit, scan_more, scan_end;
    logic              is_full;
    logic              shift_move, shift_stop, shift_bottom;
    logic              read_ok;
    logic [CNT_W-1:0]  iss_dec;
    logic [ADDR_W-1:0] pend_inc;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // scan: one stored entry checked per cycle as its read data returns
    assign scan_hit  = pend_reg && covers(rd_data, nw_reg);
    assign scan_more = iss_reg < count_reg;
    assign scan_end  = !scan_hit && !scan_more && !pend_reg;
    assign is_full   = (count_reg == CNT_W'(CAPACITY));

    // shift: the returning entry moves up one place while it is greater.
    // Writes go to pend_idx + 1, reads to lower addresses, so a write
    // never meets a read of the same entry and no forwarding is needed.
    assign shift_move   = pend_reg && less_than(nw_reg, rd_data);
    assign shift_stop   = pend_reg && !shift_move;
    assign shift_bottom = !pend_reg && (iss_reg == '0);
    assign iss_dec      = iss_reg - CNT_W'(1);
    assign pend_inc     = pend_idx_reg + ADDR_W'(1);

    assign read_ok = ({1'b0, pos_reg} < count_reg);

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = (s_req_type == REQ_READ) ? ST_READ : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_hit) begin
                    state_next = ST_FIN;
                end else if (scan_end) begin
                    state_next = is_full ? ST_FIN : ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (shift_stop || shift_bottom) begin
                    state_next = ST_FIN;
                end
            end
            ST_READ: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath, RAM control and output register
    // ---------------------------------------------------------------
    always_comb begin
        count_next    = count_reg;
        nw_next       = nw_reg;
        status_next   = status_reg;
        pos_next      = pos_reg;
        iss_next      = iss_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        m_pos_next    = m_pos_reg;
        m_vals_next   = m_vals_reg;

        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = nw_reg;
        rd_en   = 1'b0;
        rd_addr = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    nw_next   = {s_num_f, s_num_e, s_num_d, s_num_c, s_num_b, s_num_a};
                    pos_next  = s_read_index;
                    iss_next  = '0;
                    pend_next = 1'b0;
                end
            end
            ST_SCAN: begin
                if (scan_hit) begin
                    status_next = STAT_DUPLICATE;
                    pos_next    = pend_idx_reg;
                    pend_next   = 1'b0;
                end else if (scan_more) begin
                    rd_en         = 1'b1;
                    rd_addr       = iss_reg[ADDR_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = iss_reg[ADDR_W-1:0];
                    iss_next      = iss_reg + CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                    if (scan_end) begin
                        if (is_full) begin
                            status_next = STAT_FULL;
                            pos_next    = '0;
                        end else begin
                            iss_next = count_reg;
                        end
                    end
                end
            end
            ST_SHIFT: begin
                if (shift_stop) begin
                    wr_en       = 1'b1;
                    wr_addr     = pend_inc;
                    wr_data     = nw_reg;
                    status_next = STAT_INSERTED;
                    pos_next    = pend_inc;
                    count_next  = count_reg + CNT_W'(1);
                    pend_next   = 1'b0;
                end else if (shift_bottom) begin
                    wr_en       = 1'b1;
                    wr_addr     = '0;
                    wr_data     = nw_reg;
                    status_next = STAT_INSERTED;
                    pos_next    = '0;
                    count_next  = count_reg + CNT_W'(1);
                end else begin
                    if (shift_move) begin
                        wr_en   = 1'b1;
                        wr_addr = pend_inc;
                        wr_data = rd_data;
                    end
                    // read the next lower entry ahead of the compare
                    if (iss_reg != '0) begin
                        rd_en         = 1'b1;
                        rd_addr       = iss_dec[ADDR_W-1:0];
                        pend_next     = 1'b1;
                        pend_idx_next = iss_dec[ADDR_W-1:0];
                        iss_next      = iss_dec;
                    end else begin
                        pend_next = 1'b0;
                    end
                end
            end
            ST_READ: begin
                if (read_ok) begin
                    rd_en       = 1'b1;
                    rd_addr     = pos_reg;
                    status_next = STAT_READ_OK;
                end else begin
                    status_next = STAT_OUT_RANGE;
                end
            end
            ST_FIN: begin
                // rd_data holds: no read is issued in this state
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_count_next  = count_reg;
                    m_pos_next    = pos_reg;
                    m_vals_next   = (status_reg == STAT_READ_OK) ? rd_data : '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        nw_reg       <= nw_next;
        status_reg   <= status_next;
        pos_reg      <= pos_next;
        iss_reg      <= iss_next;
        pend_idx_reg <= pend_idx_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
        m_pos_reg    <= m_pos_next;
        m_vals_reg   <= m_vals_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_count_reg;
    assign m_position    = m_pos_reg;
    assign m_out_a       = m_vals_reg[0];
    assign m_out_b       = m_vals_reg[1];
    assign m_out_c       = m_vals_reg[2];
    assign m_out_d       = m_vals_reg[3];
    assign m_out_e       = m_vals_reg[4];
    assign m_out_f       = m_vals_reg[5];

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // table never grows past its capacity
    `ASSERT_RST(a_count_cap, aclk, aresetn, count_reg <= CNT_W'(CAPACITY))
    // every RAM read targets a stored entry
    `ASSERT_RST(a_rd_valid, aclk, aresetn, rd_en |-> ({1'b0, rd_addr} < count_reg))
    // an insert that ends the shift adds exactly one entry
    `ASSERT_RST(a_count_inc, aclk, aresetn,
        (state_reg == ST_SHIFT && state_next == ST_FIN) |=>
            (count_reg == $past(count_reg) + CNT_W'(1)))
    // the RAM is written only while shifting
    `ASSERT_RST(a_wr_shift, aclk, aresetn, wr_en |-> (state_reg == ST_SHIFT))

endmodule

`default_nettype wire
